// ===== rtl/core/issp_vs_pkg.sv =====
// Shared types and constants for the ISSP vector serializer.
// Used by the channel interfaces and the serializer core; no dependencies.
`default_nettype none

package issp_vs_pkg;

	// Payload widths fixed by the item format
	localparam int unsigned VEC_IN_W  = 19;
	localparam int unsigned DRIVE_W   = 2;
	localparam int unsigned KIND_W    = 2;
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned TIMER_W   = 24;

	// APB register file
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	typedef logic [DRIVE_W-1:0] drive_t;
	typedef logic [KIND_W-1:0]  kind_t;
	typedef logic [TIMER_W-1:0] timer_t;

	// SDATA drive codes
	localparam drive_t DRV_LOW  = 2'd0;
	localparam drive_t DRV_HIGH = 2'd1;
	localparam drive_t DRV_Z    = 2'd2;

	// Vector kinds
	localparam kind_t KIND_ZERO  = 2'd0;
	localparam kind_t KIND_WRITE = 2'd1;
	localparam kind_t KIND_READ  = 2'd2;

	// Item opcodes
	localparam logic OP_START = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Register index (paddr bit 2)
	localparam logic REG_SHORT_WAIT   = 1'b0;
	localparam logic REG_POLL_TIMEOUT = 1'b1;

	// Register reset values
	localparam timer_t SHORT_WAIT_RST   = 24'd10;
	localparam timer_t POLL_TIMEOUT_RST = 24'd100000;

	// Sequence lengths
	localparam int unsigned ZERO_VECTOR_BITS = 22;
	localparam int unsigned WRITE_TAIL_ONES  = 3;
	localparam int unsigned READ_DATA_BITS   = 8;

endpackage

`default_nettype wire

// ===== rtl/core/issp_vs_if.sv =====
// Valid/ready channel interfaces for the serializer: command items in, result items out.
// Depends on issp_vs_pkg.
`default_nettype none

interface issp_vs_cmd_if;
	logic                                   valid;
	logic                                   ready;
	logic                                   op;
	issp_vs_pkg::kind_t                     kind;
	logic                                   ssc_flag;
	logic [issp_vs_pkg::VEC_IN_W-1:0]       vector_bits;
	logic                                   sdata_in;

	modport source (output valid, op, kind, ssc_flag, vector_bits, sdata_in, input ready);
	modport sink   (input valid, op, kind, ssc_flag, vector_bits, sdata_in, output ready);
endinterface

interface issp_vs_rsp_if;
	logic                                   valid;
	logic                                   ready;
	issp_vs_pkg::drive_t                    pin_drive;
	logic                                   clock_strobe;
	logic                                   busy_res;
	logic                                   done_res;
	logic [issp_vs_pkg::BYTE_W-1:0]         rx_byte;
	logic                                   timeout_error;

	modport source (output valid, pin_drive, clock_strobe, busy_res, done_res, rx_byte,
		timeout_error, input ready);
	modport sink   (input valid, pin_drive, clock_strobe, busy_res, done_res, rx_byte,
		timeout_error, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/issp_vector_serializer_core.sv =====
// ISSP vector serializer core: sequencer, result register and APB timing registers.
// Depends on issp_vs_pkg and the channel interfaces in issp_vs_if.sv.
`default_nettype none

// Master side of a two-wire ISSP link, advanced one tick per command item. A start
// item (op 0) loads a zero, write or read vector while idle; each tick item (op 1)
// advances the sequence by one SDATA bit and returns one result item with the pin
// drive, the SCLK strobe, busy/done status, the read byte on completion and the
// poll timeout flag. Every command item yields exactly one result item. The core
// takes one item per clock unless a held result is not taken, which stalls new
// items: each item passes through one layer of next-state logic into the result
// register, and a new item is accepted in the same cycle the held result is taken.
// short_wait_ticks (addr 0x0) and poll_timeout_ticks (addr 0x4) set the SSC poll
// windows; write them only while the link is idle.
module issp_vector_serializer_core #(
	parameter int unsigned VECTOR_BITS   = 19,
	parameter int unsigned TRAILER_ZEROS = 40
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	issp_vs_cmd_if.sink                                cmd,
	issp_vs_rsp_if.source                              rsp,
	input  wire logic                                  psel,
	input  wire logic                                  penable,
	input  wire logic                                  pwrite,
	input  wire logic [issp_vs_pkg::APB_ADDR_W-1:0]    paddr,
	input  wire logic [issp_vs_pkg::APB_DATA_W-1:0]    pwdata,
	output logic      [issp_vs_pkg::APB_DATA_W-1:0]    prdata,
	output logic                                       pready
);

	// Counter must hold the longest run loaded into it
	localparam int unsigned MAX_A   = (VECTOR_BITS > issp_vs_pkg::ZERO_VECTOR_BITS) ?
		VECTOR_BITS : issp_vs_pkg::ZERO_VECTOR_BITS;
	localparam int unsigned MAX_CNT = (TRAILER_ZEROS > MAX_A) ? TRAILER_ZEROS : MAX_A;
	localparam int unsigned CNT_W   = $clog2(MAX_CNT + 1);
	localparam int unsigned RD_ADDR_BITS = VECTOR_BITS - issp_vs_pkg::READ_DATA_BITS;

	typedef enum logic [3:0] {
		PH_IDLE, PH_ZEROS, PH_WR_BITS, PH_WR_ONES, PH_RD_ADDR, PH_RD_TURN,
		PH_RD_DATA, PH_RD_TAIL_Z, PH_RD_TAIL_ONE, PH_SSC_Z, PH_SHORT_WAIT,
		PH_POLL_LOW, PH_TRAILER
	} phase_t;

	typedef logic [CNT_W-1:0]       cnt_t;
	typedef logic [VECTOR_BITS-1:0] word_t;
	typedef logic [issp_vs_pkg::BYTE_W-1:0] byte_t;

	// Sequencer state
	phase_t              phase_q, phase_d;
	cnt_t                cnt_q, cnt_d;
	word_t               shift_q, shift_d;
	byte_t               accum_q, accum_d;
	issp_vs_pkg::timer_t timer_q, timer_d, timer_inc;
	issp_vs_pkg::kind_t  pkind_q, pkind_d;
	logic                pssc_q, pssc_d;

	// Configuration registers
	issp_vs_pkg::timer_t short_wait_q, poll_timeout_q;

	// Result of the current item
	issp_vs_pkg::drive_t drive_d;
	logic                strobe_d, done_d, err_d;

	// Result register
	logic                rsp_valid_q;
	issp_vs_pkg::drive_t drive_q;
	logic                strobe_q, busy_q, done_q, err_q;
	byte_t               byte_q;

	logic accept;
	logic cfg_wr;

	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;

	assign timer_inc = (timer_q == '1) ? timer_q : timer_q + issp_vs_pkg::TIMER_W'(1);

	// Next state and result for one item
	always_comb begin
		phase_d  = phase_q;
		cnt_d    = cnt_q;
		shift_d  = shift_q;
		accum_d  = accum_q;
		timer_d  = timer_q;
		pkind_d  = pkind_q;
		pssc_d   = pssc_q;
		drive_d  = issp_vs_pkg::DRV_Z;
		strobe_d = 1'b0;
		done_d   = 1'b0;
		err_d    = 1'b0;

		if (cmd.op == issp_vs_pkg::OP_START) begin
			if (phase_q == PH_IDLE && (cmd.kind == issp_vs_pkg::KIND_ZERO ||
				cmd.kind == issp_vs_pkg::KIND_WRITE || cmd.kind == issp_vs_pkg::KIND_READ)) begin
				pkind_d = cmd.kind;
				pssc_d  = cmd.ssc_flag;
				shift_d = VECTOR_BITS'(cmd.vector_bits);
				accum_d = '0;
				timer_d = '0;
				if (cmd.kind == issp_vs_pkg::KIND_ZERO) begin
					phase_d = PH_ZEROS;
					cnt_d   = CNT_W'(issp_vs_pkg::ZERO_VECTOR_BITS);
				end else if (cmd.kind == issp_vs_pkg::KIND_WRITE) begin
					phase_d = PH_WR_BITS;
					cnt_d   = CNT_W'(VECTOR_BITS);
				end else begin
					phase_d = PH_RD_ADDR;
					cnt_d   = CNT_W'(RD_ADDR_BITS);
				end
			end
		end else begin
			case (phase_q)
				PH_ZEROS: begin
					drive_d  = issp_vs_pkg::DRV_LOW;
					strobe_d = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_d == '0) begin
						phase_d = pssc_q ? PH_SSC_Z : PH_IDLE;
						done_d  = !pssc_q;
					end
				end
				PH_WR_BITS: begin
					// MSB of the shift word goes out first
					drive_d  = shift_q[VECTOR_BITS-1] ? issp_vs_pkg::DRV_HIGH : issp_vs_pkg::DRV_LOW;
					strobe_d = 1'b1;
					shift_d  = {shift_q[VECTOR_BITS-2:0], 1'b0};
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_d == '0) begin
						phase_d = PH_WR_ONES;
						cnt_d   = CNT_W'(issp_vs_pkg::WRITE_TAIL_ONES);
					end
				end
				PH_WR_ONES: begin
					drive_d  = issp_vs_pkg::DRV_HIGH;
					strobe_d = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_d == '0) begin
						phase_d = pssc_q ? PH_SSC_Z : PH_IDLE;
						done_d  = !pssc_q;
					end
				end
				PH_RD_ADDR: begin
					drive_d  = shift_q[VECTOR_BITS-1] ? issp_vs_pkg::DRV_HIGH : issp_vs_pkg::DRV_LOW;
					strobe_d = 1'b1;
					shift_d  = {shift_q[VECTOR_BITS-2:0], 1'b0};
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_d == '0) begin
						phase_d = PH_RD_TURN;
					end
				end
				PH_RD_TURN: begin
					strobe_d = 1'b1;
					phase_d  = PH_RD_DATA;
					cnt_d    = CNT_W'(issp_vs_pkg::READ_DATA_BITS);
				end
				PH_RD_DATA: begin
					// sample SDATA, MSB first
					strobe_d = 1'b1;
					accum_d  = {accum_q[issp_vs_pkg::BYTE_W-2:0], cmd.sdata_in};
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_d == '0) begin
						phase_d = PH_RD_TAIL_Z;
					end
				end
				PH_RD_TAIL_Z: begin
					strobe_d = 1'b1;
					phase_d  = PH_RD_TAIL_ONE;
				end
				PH_RD_TAIL_ONE: begin
					drive_d  = issp_vs_pkg::DRV_HIGH;
					strobe_d = 1'b1;
					phase_d  = pssc_q ? PH_SSC_Z : PH_IDLE;
					done_d   = !pssc_q;
				end
				PH_SSC_Z: begin
					strobe_d = 1'b1;
					timer_d  = '0;
					phase_d  = PH_SHORT_WAIT;
				end
				PH_SHORT_WAIT: begin
					if (cmd.sdata_in) begin
						phase_d = PH_POLL_LOW;
					end else if (timer_q > short_wait_q) begin
						phase_d = PH_TRAILER;
						cnt_d   = CNT_W'(TRAILER_ZEROS);
					end
					timer_d = timer_inc;
				end
				PH_POLL_LOW: begin
					if (!cmd.sdata_in) begin
						phase_d = PH_TRAILER;
						cnt_d   = CNT_W'(TRAILER_ZEROS);
					end else if (timer_q > poll_timeout_q) begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
						err_d   = 1'b1;
					end
					timer_d = timer_inc;
				end
				PH_TRAILER: begin
					drive_d  = issp_vs_pkg::DRV_LOW;
					strobe_d = 1'b1;
					cnt_d    = cnt_q - CNT_W'(1);
					if (cnt_d == '0) begin
						phase_d = PH_IDLE;
						done_d  = 1'b1;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	// Sequencer state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			cnt_q       <= '0;
			shift_q     <= '0;
			accum_q     <= '0;
			timer_q     <= '0;
			pkind_q     <= issp_vs_pkg::KIND_ZERO;
			pssc_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			drive_q     <= issp_vs_pkg::DRV_Z;
			strobe_q    <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			byte_q      <= '0;
			err_q       <= 1'b0;
		end else begin
			if (accept) begin
				phase_q     <= phase_d;
				cnt_q       <= cnt_d;
				shift_q     <= shift_d;
				accum_q     <= accum_d;
				timer_q     <= timer_d;
				pkind_q     <= pkind_d;
				pssc_q      <= pssc_d;
				rsp_valid_q <= 1'b1;
				drive_q     <= drive_d;
				strobe_q    <= strobe_d;
				busy_q      <= (phase_d != PH_IDLE);
				done_q      <= done_d;
				byte_q      <= (done_d && pkind_q == issp_vs_pkg::KIND_READ) ? accum_d : '0;
				err_q       <= err_d;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.pin_drive     = drive_q;
	assign rsp.clock_strobe  = strobe_q;
	assign rsp.busy_res      = busy_q;
	assign rsp.done_res      = done_q;
	assign rsp.rx_byte       = byte_q;
	assign rsp.timeout_error = err_q;

	// APB registers, decoded on paddr bit 2
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_wait_q   <= issp_vs_pkg::SHORT_WAIT_RST;
			poll_timeout_q <= issp_vs_pkg::POLL_TIMEOUT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == issp_vs_pkg::REG_SHORT_WAIT) begin
				short_wait_q <= pwdata[issp_vs_pkg::TIMER_W-1:0];
			end else begin
				poll_timeout_q <= pwdata[issp_vs_pkg::TIMER_W-1:0];
			end
		end
	end

	always_comb begin
		case (paddr[2])
			issp_vs_pkg::REG_SHORT_WAIT:   prdata = issp_vs_pkg::APB_DATA_W'(short_wait_q);
			issp_vs_pkg::REG_POLL_TIMEOUT: prdata = issp_vs_pkg::APB_DATA_W'(poll_timeout_q);
			default:                       prdata = '0;
		endcase
	end

	// A held result blocks new items until it is taken
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !cmd.ready)
		else $error("item accepted while result register stalled");

	// A timeout ends the vector
	a_timeout_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && err_q |-> done_q && !busy_q && phase_q == PH_IDLE)
		else $error("timeout without completion");

	// The read byte only shows with completion of a read vector
	a_byte_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && byte_q != '0 |-> done_q && pkind_q == issp_vs_pkg::KIND_READ)
		else $error("read byte outside completion");

	// Idle ticks never clock the link
	a_idle_no_clock: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_IDLE |=> !strobe_q && drive_q == issp_vs_pkg::DRV_Z)
		else $error("clock or drive while idle");

endmodule

`default_nettype wire

// ===== sim/issp_vs_link_checker.sv =====
// Result checker for the ISSP vector serializer: predicts one result item per command item
// and compares it field by field with what the core returns.
// Depends on issp_vs_pkg and the channel interfaces in issp_vs_if.sv.
`default_nettype none

module issp_vs_link_checker
	import issp_vs_pkg::*;
#(
	parameter int unsigned VECTOR_BITS   = 19,
	parameter int unsigned TRAILER_ZEROS = 40
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	issp_vs_cmd_if                      cmd,
	issp_vs_rsp_if                      rsp,
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic                   pready,
	input  wire logic [APB_ADDR_W-1:0]  paddr,
	input  wire logic [APB_DATA_W-1:0]  pwdata,
	output int unsigned                 mismatch_count,
	output int unsigned                 pending_count,
	output int unsigned                 checked_count,
	output int unsigned                 vector_count,
	output int unsigned                 timeout_count
);

	typedef enum logic [3:0] {
		LINK_IDLE, LINK_ZEROS, LINK_WR_BITS, LINK_WR_ONES, LINK_RD_ADDR, LINK_RD_TURN,
		LINK_RD_DATA, LINK_RD_TAIL_Z, LINK_RD_TAIL_ONE, LINK_SSC_Z, LINK_SHORT_WAIT,
		LINK_POLL_LOW, LINK_TRAILER
	} link_phase_t;

	typedef struct packed {
		drive_t              pin_drive;
		logic                clock_strobe;
		logic                busy_res;
		logic                done_res;
		logic [BYTE_W-1:0]   rx_byte;
		logic                timeout_error;
	} link_result_t;

	localparam timer_t TIMER_TOP = '1;

	// timing registers as last written over APB
	timer_t short_wait_cfg;
	timer_t poll_limit_cfg;

	// predicted link state
	link_phase_t             link_phase;
	logic [5:0]              bits_left;
	logic [VECTOR_BITS-1:0]  out_word;
	logic [BYTE_W-1:0]       sampled_byte;
	timer_t                  poll_timer;
	kind_t                   vec_kind;
	logic                    vec_has_ssc;

	link_result_t due_results[$];

	// end of the vector body: either on to the SSC poll or complete
	function automatic logic finish_body();
		if (vec_has_ssc) begin
			link_phase = LINK_SSC_Z;
			return 1'b0;
		end
		link_phase = LINK_IDLE;
		return 1'b1;
	endfunction

	// advance the link by one command item and return the pin activity it causes
	function automatic link_result_t advance_link(input logic op, input kind_t kind,
			input logic ssc, input logic [VEC_IN_W-1:0] vec, input logic sd);
		link_result_t r;
		logic late;
		logic polling;
		r = '0;
		r.pin_drive = DRV_Z;
		polling = (link_phase == LINK_SHORT_WAIT || link_phase == LINK_POLL_LOW);
		if (op == OP_START) begin
			// only an idle link takes a new vector; the spare kind code is dropped
			if (link_phase == LINK_IDLE &&
					(kind == KIND_ZERO || kind == KIND_WRITE || kind == KIND_READ)) begin
				vec_kind = kind;
				vec_has_ssc = ssc;
				out_word = VECTOR_BITS'(vec);
				sampled_byte = '0;
				poll_timer = '0;
				case (kind)
				KIND_ZERO: begin
					link_phase = LINK_ZEROS;
					bits_left = 6'(ZERO_VECTOR_BITS);
				end
				KIND_WRITE: begin
					link_phase = LINK_WR_BITS;
					bits_left = 6'(VECTOR_BITS);
				end
				default: begin
					link_phase = LINK_RD_ADDR;
					bits_left = 6'(VECTOR_BITS - READ_DATA_BITS);
				end
				endcase
			end
		end else begin
			case (link_phase)
			LINK_ZEROS: begin
				r.pin_drive = DRV_LOW;
				r.clock_strobe = 1'b1;
				if (bits_left != 0) bits_left = bits_left - 1'b1;
				if (bits_left == 0) r.done_res = finish_body();
			end
			LINK_WR_BITS: begin
				r.clock_strobe = 1'b1;
				r.pin_drive = (bits_left != 0 && out_word[bits_left - 1'b1]) ? DRV_HIGH : DRV_LOW;
				if (bits_left != 0) bits_left = bits_left - 1'b1;
				if (bits_left == 0) begin
					link_phase = LINK_WR_ONES;
					bits_left = 6'(WRITE_TAIL_ONES);
				end
			end
			LINK_WR_ONES: begin
				r.pin_drive = DRV_HIGH;
				r.clock_strobe = 1'b1;
				if (bits_left != 0) bits_left = bits_left - 1'b1;
				if (bits_left == 0) r.done_res = finish_body();
			end
			LINK_RD_ADDR: begin
				// address bits sit above the data byte in the vector
				r.clock_strobe = 1'b1;
				r.pin_drive = (bits_left != 0 && out_word[bits_left - 1'b1 + READ_DATA_BITS]) ?
					DRV_HIGH : DRV_LOW;
				if (bits_left != 0) bits_left = bits_left - 1'b1;
				if (bits_left == 0) link_phase = LINK_RD_TURN;
			end
			LINK_RD_TURN: begin
				r.clock_strobe = 1'b1;
				link_phase = LINK_RD_DATA;
				bits_left = 6'(READ_DATA_BITS);
			end
			LINK_RD_DATA: begin
				r.clock_strobe = 1'b1;
				sampled_byte = {sampled_byte[BYTE_W-2:0], sd};
				if (bits_left != 0) bits_left = bits_left - 1'b1;
				if (bits_left == 0) link_phase = LINK_RD_TAIL_Z;
			end
			LINK_RD_TAIL_Z: begin
				r.clock_strobe = 1'b1;
				link_phase = LINK_RD_TAIL_ONE;
			end
			LINK_RD_TAIL_ONE: begin
				r.pin_drive = DRV_HIGH;
				r.clock_strobe = 1'b1;
				r.done_res = finish_body();
			end
			LINK_SSC_Z: begin
				r.clock_strobe = 1'b1;
				poll_timer = '0;
				link_phase = LINK_SHORT_WAIT;
			end
			LINK_SHORT_WAIT: begin
				if (sd) begin
					link_phase = LINK_POLL_LOW;
				end else if (poll_timer > short_wait_cfg) begin
					link_phase = LINK_TRAILER;
					bits_left = 6'(TRAILER_ZEROS);
				end
			end
			LINK_POLL_LOW: begin
				late = poll_timer > poll_limit_cfg;
				if (!sd) begin
					link_phase = LINK_TRAILER;
					bits_left = 6'(TRAILER_ZEROS);
				end else if (late) begin
					link_phase = LINK_IDLE;
					r.done_res = 1'b1;
					r.timeout_error = 1'b1;
				end
			end
			LINK_TRAILER: begin
				r.pin_drive = DRV_LOW;
				r.clock_strobe = 1'b1;
				if (bits_left != 0) bits_left = bits_left - 1'b1;
				if (bits_left == 0) begin
					link_phase = LINK_IDLE;
					r.done_res = 1'b1;
				end
			end
			default: begin
				link_phase = LINK_IDLE;
			end
			endcase
			// poll timer saturates at its top value
			if (polling && poll_timer != TIMER_TOP) poll_timer = poll_timer + 1'b1;
		end
		r.busy_res = (link_phase != LINK_IDLE);
		r.rx_byte = (r.done_res && vec_kind == KIND_READ) ? sampled_byte : '0;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	// register snoop, prediction on command accept, compare on result accept
	always @(posedge clk or negedge arst_n) begin
		link_result_t want;
		if (!arst_n) begin
			short_wait_cfg = SHORT_WAIT_RST;
			poll_limit_cfg = POLL_TIMEOUT_RST;
			link_phase = LINK_IDLE;
			bits_left = '0;
			out_word = '0;
			sampled_byte = '0;
			poll_timer = '0;
			vec_kind = KIND_ZERO;
			vec_has_ssc = 1'b0;
			due_results.delete();
			mismatch_count = 0;
			pending_count = 0;
			checked_count = 0;
			vector_count = 0;
			timeout_count = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_SHORT_WAIT) short_wait_cfg = pwdata[TIMER_W-1:0];
				else poll_limit_cfg = pwdata[TIMER_W-1:0];
			end
			if (cmd.valid && cmd.ready) begin
				want = advance_link(cmd.op, cmd.kind, cmd.ssc_flag, cmd.vector_bits,
					cmd.sdata_in);
				due_results.push_back(want);
				if (want.done_res) vector_count++;
				if (want.timeout_error) timeout_count++;
			end
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					$error("result item arrived with no expectation pending");
					mismatch_count++;
				end else begin
					want = due_results.pop_front();
					check_field("pin_drive", 32'(want.pin_drive), 32'(rsp.pin_drive));
					check_field("clock_strobe", 32'(want.clock_strobe), 32'(rsp.clock_strobe));
					check_field("busy_res", 32'(want.busy_res), 32'(rsp.busy_res));
					check_field("done_res", 32'(want.done_res), 32'(rsp.done_res));
					check_field("rx_byte", 32'(want.rx_byte), 32'(rsp.rx_byte));
					check_field("timeout_error", 32'(want.timeout_error), 32'(rsp.timeout_error));
					checked_count++;
				end
			end
			pending_count = due_results.size();
		end
	end

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Top of the ISSP vector serializer testbench: clock, reset, command and APB stimulus,
// result back-pressure, watchdog and verdict.
// Depends on issp_vs_pkg, issp_vs_if.sv, the serializer core and issp_vs_link_checker.
`default_nettype none

module testbench;
	import issp_vs_pkg::*;

	localparam int unsigned VECTOR_BITS       = 19;
	localparam int unsigned TRAILER_ZEROS     = 40;
	localparam int unsigned STALL_LIMIT       = 4000;
	localparam int unsigned HOLD_CYCLES       = 400;
	localparam int unsigned ITEMS_PER_SETTING = 350;
	// ticks allowed to bring a busy link back to idle
	localparam int unsigned SETTLE_LIMIT      = 200;
	// kind code with no vector behind it
	localparam kind_t       KIND_SPARE        = 2'd3;

	logic clk = 1'b0;
	logic arst_n;

	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [APB_ADDR_W-1:0]  paddr;
	logic [APB_DATA_W-1:0]  pwdata;
	logic [APB_DATA_W-1:0]  prdata;
	logic                   pready;

	int unsigned mismatch_count, pending_count, checked_count, vector_count, timeout_count;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_requests = 0;
	int unsigned items_sent = 0;
	int unsigned quiet_cycles = 0;
	logic        last_busy = 1'b0;

	issp_vs_cmd_if cmd_ch();
	issp_vs_rsp_if rsp_ch();

	issp_vector_serializer_core #(
		.VECTOR_BITS(VECTOR_BITS),
		.TRAILER_ZEROS(TRAILER_ZEROS)
	) uut (
		.clk, .arst_n, .cmd(cmd_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	issp_vs_link_checker #(
		.VECTOR_BITS(VECTOR_BITS),
		.TRAILER_ZEROS(TRAILER_ZEROS)
	) link_check (
		.clk, .arst_n, .cmd(cmd_ch), .rsp(rsp_ch),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.mismatch_count, .pending_count, .checked_count, .vector_count, .timeout_count
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on cycles with no item moving; also remember the last busy flag seen
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (rsp_ch.valid && rsp_ch.ready) last_busy <= rsp_ch.busy_res;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side: random back-pressure, plus a long hold whenever one is requested
	initial begin
		int unsigned hold_left;
		int unsigned holds_done;
		hold_left = 0;
		holds_done = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (holds_done != hold_requests) begin
				rsp_ch.ready <= 1'b0;
				hold_left = HOLD_CYCLES - 1;
				holds_done = holds_done + 1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// offer one command item, with random gaps first; returns at the negedge after accept
	task automatic send_item(input logic op, input kind_t kind, input logic ssc,
			input logic [VEC_IN_W-1:0] vec, input logic sd);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.op <= op;
		cmd_ch.kind <= kind;
		cmd_ch.ssc_flag <= ssc;
		cmd_ch.vector_bits <= vec;
		cmd_ch.sdata_in <= sd;
		do @(posedge clk); while (!cmd_ch.ready);
		@(negedge clk);
		items_sent++;
	endtask

	// tick item; the start-only fields carry noise
	task automatic send_tick(input logic sd);
		send_item(OP_TICK, kind_t'($urandom_range(3)), 1'($urandom_range(1)),
			VEC_IN_W'($urandom), sd);
	endtask

	task automatic write_reg(input logic index, input timer_t value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic set_timing(input timer_t short_wait, input timer_t poll_limit);
		write_reg(REG_SHORT_WAIT, short_wait);
		write_reg(REG_POLL_TIMEOUT, poll_limit);
	endtask

	// stop offering and wait for every expected result
	task automatic wait_results();
		cmd_ch.valid <= 1'b0;
		@(negedge clk);
		while (pending_count != 0) @(negedge clk);
	endtask

	// bring the link back to idle; alternating SDATA gets any poll out of its wait
	task automatic settle_link();
		logic sd;
		int unsigned ticks;
		sd = 1'b1;
		ticks = 0;
		wait_results();
		while (last_busy && ticks < SETTLE_LIMIT) begin
			send_tick(sd);
			sd = !sd;
			ticks++;
			wait_results();
		end
		repeat (4) @(negedge clk);
	endtask

	// one random stretch: mostly whole vectors, some with a poll, some noise and cut-off vectors
	task automatic run_sequence();
		int unsigned pick;
		int unsigned n;
		kind_t kind;
		logic ssc;
		pick = $urandom_range(99);
		if (pick < 10) begin
			n = $urandom_range(5, 1);
			repeat (n) send_item(1'($urandom_range(1)), kind_t'($urandom_range(3)),
				1'($urandom_range(1)), VEC_IN_W'($urandom), 1'($urandom_range(1)));
		end else begin
			kind = kind_t'($urandom_range(2));
			ssc = 1'($urandom_range(1));
			send_item(OP_START, kind, ssc, VEC_IN_W'($urandom), 1'($urandom_range(1)));
			// every vector body is 22 ticks long
			n = (pick < 15) ? $urandom_range(21) : 22;
			repeat (n) send_tick(1'($urandom_range(1)));
			if (pick >= 15 && ssc) begin
				send_tick(1'($urandom_range(1)));
				repeat ($urandom_range(6)) send_tick(1'b0);
				repeat ($urandom_range(8)) send_tick(1'b1);
				send_tick(1'b0);
				repeat (TRAILER_ZEROS) send_tick(1'($urandom_range(1)));
			end
			repeat ($urandom_range(2)) send_tick(1'($urandom_range(1)));
		end
	endtask

	initial begin
		int unsigned goal;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.op = OP_START;
		cmd_ch.kind = KIND_ZERO;
		cmd_ch.ssc_flag = 1'b0;
		cmd_ch.vector_bits = '0;
		cmd_ch.sdata_in = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short poll windows for the directed part
		set_timing(24'd2, 24'd3);

		// tick while idle, spare kind ignored, all-ones write, start while busy
		send_tick(1'b1);
		send_item(OP_START, KIND_SPARE, 1'b1, '1, 1'b1);
		send_tick(1'b0);
		send_item(OP_START, KIND_WRITE, 1'b0, '1, 1'b0);
		send_item(OP_START, KIND_READ, 1'b1, '0, 1'b1);
		repeat (22) send_tick(1'($urandom_range(1)));

		// random part over several timing settings and idling patterns
		for (int p = 0; p < 4; p++) begin
			settle_link();
			case (p)
			0: set_timing(timer_t'($urandom_range(12)), timer_t'($urandom_range(40)));
			1: set_timing('0, '0);
			2: set_timing('1, '1);
			default: set_timing(timer_t'($urandom_range(4)), timer_t'($urandom_range(16)));
			endcase
			send_idle_pct = (p == 0) ? 36 : (p == 1) ? 67 : 0;
			recv_idle_pct <= (p == 0) ? 67 : (p == 1) ? 36 : 0;
			// long result hold while the sender keeps pushing
			if (p == 2) hold_requests <= hold_requests + 1;
			goal = items_sent + ITEMS_PER_SETTING;
			while (items_sent < goal) run_sequence();
		end
		settle_link();
		repeat (8) @(negedge clk);

		$display("Covered %0d command items over five poll timing settings, idling on either",
			items_sent);
		$display("side and a long result hold: %0d results checked, %0d vectors, %0d timeouts.",
			checked_count, vector_count, timeout_count);
		if (mismatch_count == 0 && pending_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
